// ----- design/message_slot_buffer_defines.svh -----
// Assertion helpers for the message slot buffer.
`ifndef MESSAGE_SLOT_BUFFER_DEFINES_SVH
`define MESSAGE_SLOT_BUFFER_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define MSB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define MSB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/msb_pkg.sv -----
package msb_pkg;

  localparam int SlotsDefault = 32;
  localparam int SlotW        = 5;
  localparam int CountW       = 6;
  localparam int HandleW      = 16;
  localparam int PrioW        = 2;
  localparam int TickW        = 32;
  localparam int PaddrW       = 3;
  localparam int PdataW       = 32;

  localparam logic             ModeAdd     = 1'b0;
  localparam logic             ModeRecv    = 1'b1;
  localparam logic [PrioW-1:0] PrioCaution = 2'd2;

  // register index 0 sits at byte 0; bit 2 of paddr selects the index
  localparam logic RegOvfHandle = 1'b0;

  typedef struct packed {
    logic [HandleW-1:0] handle;
    logic [PrioW-1:0]   prio;
    logic [TickW-1:0]   tick;
  } slot_rec_t;

endpackage

// ----- design/message_slot_buffer.sv -----
// An accepted item's result is registered into the output register.
// Throughput: one item per cycle while the output is not stalled; both slot
// searches are combinational priority encoders over the pending map, and the
// record store takes its write and its registered read at the accepting edge.
// Reset (rst_ni low, asynchronous): pending map, count, caution flag, output
// valid and the overflow handle register clear; slot records are not cleared.
`include "message_slot_buffer_defines.svh"

module message_slot_buffer import msb_pkg::*; #(
  parameter int SLOTS = SlotsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,

  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PaddrW-1:0]  paddr,
  input  logic [PdataW-1:0]  pwdata,
  output logic [PdataW-1:0]  prdata,
  output logic               pready,

  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               mode_i,
  input  logic [HandleW-1:0] text_handle_i,
  input  logic [PrioW-1:0]   priority_req_i,
  input  logic [TickW-1:0]   tick_i,

  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [SlotW-1:0]   slot_o,
  output logic               found_o,
  output logic               overflow_o,
  output logic [HandleW-1:0] out_handle_o,
  output logic [PrioW-1:0]   out_priority_o,
  output logic [TickW-1:0]   out_tick_o,
  output logic [CountW-1:0]  pending_count_o,
  output logic               master_caution_o
);

  localparam int IdxW = $clog2(SLOTS);
  localparam int CntW = $clog2(SLOTS + 1);

  logic [HandleW-1:0] ovf_handle_q;
  logic               cfg_wr;

  logic [SLOTS-1:0]   pend_q, pend_d, free_vec;
  logic [CntW-1:0]    count_q, count_d;
  logic               caution_q, caution_d;

  logic               add_found, rx_found;
  logic [IdxW-1:0]    add_idx, rx_idx;

  logic               accept, is_add, we, re;
  logic [IdxW-1:0]    waddr;
  slot_rec_t          wdata, rdata, rec_out;

  logic               out_valid_q;
  logic [SlotW-1:0]   slot_q, slot_d;
  logic               found_q, found_d;
  logic               ovf_q, ovf_d;
  logic               rx_hit_q, rx_hit_d;
  logic [CntW-1:0]    res_count_q;
  logic               res_caution_q;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == RegOvfHandle);
  assign prdata = (paddr[2] == RegOvfHandle) ? PdataW'(ovf_handle_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_handle_q <= '0;
    end else if (cfg_wr) begin
      ovf_handle_q <= pwdata[HandleW-1:0];
    end
  end

  // slot searches
  always_comb begin
    free_vec    = ~pend_q;
    free_vec[0] = 1'b0;
  end

  msb_ffs #(.W(SLOTS), .IdxW(IdxW)) u_ffs_free (
    .vec_i   (free_vec),
    .found_o (add_found),
    .idx_o   (add_idx)
  );

  msb_ffs #(.W(SLOTS), .IdxW(IdxW)) u_ffs_pend (
    .vec_i   (pend_q),
    .found_o (rx_found),
    .idx_o   (rx_idx)
  );

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_add     = (mode_i == ModeAdd);
  assign we         = accept && is_add;
  assign re         = accept && !is_add && rx_found;
  assign waddr      = add_found ? add_idx : '0;

  always_comb begin
    if (add_found) begin
      wdata = '{handle: text_handle_i, prio: priority_req_i, tick: tick_i};
    end else begin
      wdata = '{handle: ovf_handle_q, prio: PrioCaution, tick: tick_i};
    end
  end

  // record read lands in the store's output register at the accepting edge
  msb_store #(.Width($bits(slot_rec_t)), .Depth(SLOTS), .AddrW(IdxW)) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (rx_idx),
    .rdata_o (rdata)
  );

  // state and result
  always_comb begin
    pend_d    = pend_q;
    count_d   = count_q;
    caution_d = caution_q;
    slot_d    = '0;
    found_d   = 1'b0;
    ovf_d     = 1'b0;
    rx_hit_d  = 1'b0;
    if (accept) begin
      if (is_add) begin
        pend_d = pend_q | (SLOTS'(1) << waddr);
        if (add_found || !pend_q[0]) begin
          count_d = count_q + CntW'(1);
        end
        if (add_found) begin
          slot_d  = SlotW'(add_idx);
          found_d = 1'b1;
        end else begin
          ovf_d     = 1'b1;
          caution_d = 1'b1;
        end
      end else if (rx_found) begin
        pend_d   = pend_q & ~(SLOTS'(1) << rx_idx);
        count_d  = count_q - CntW'(1);
        slot_d   = SlotW'(rx_idx);
        found_d  = 1'b1;
        rx_hit_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      count_q     <= '0;
      caution_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q    <= pend_d;
      count_q   <= count_d;
      caution_q <= caution_d;
      if (in_ready_o) begin
        out_valid_q <= accept;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      slot_q        <= slot_d;
      found_q       <= found_d;
      ovf_q         <= ovf_d;
      rx_hit_q      <= rx_hit_d;
      res_count_q   <= count_d;
      res_caution_q <= caution_d;
    end
  end

  assign rec_out = rx_hit_q ? rdata : '0;

  assign out_valid_o      = out_valid_q;
  assign slot_o           = slot_q;
  assign found_o          = found_q;
  assign overflow_o       = ovf_q;
  assign out_handle_o     = rec_out.handle;
  assign out_priority_o   = rec_out.prio;
  assign out_tick_o       = rec_out.tick;
  assign pending_count_o  = CountW'(res_count_q);
  assign master_caution_o = res_caution_q;

  `MSB_ASSERT_NOW(a_count_matches_map, 1'b1, count_q == CntW'($countones(pend_q)), "count off")
  `MSB_ASSERT_NEXT(a_caution_sticky, caution_q, caution_q, "caution flag dropped")
  `MSB_ASSERT_NOW(a_found_excl_ovf, out_valid_o, !(found_o && overflow_o), "found with overflow")
  `MSB_ASSERT_NOW(a_ovf_sets_caution, out_valid_o && overflow_o, master_caution_o, "no caution")
  `MSB_ASSERT_NEXT(a_ovf_marks_slot0, accept && is_add && !add_found, pend_q[0], "slot 0 idle")

endmodule

// ----- design/msb_ffs.sv -----
module msb_ffs import msb_pkg::*; #(
  parameter int W    = SlotsDefault,
  parameter int IdxW = $clog2(SlotsDefault)
) (
  input  logic [W-1:0]    vec_i,
  output logic            found_o,
  output logic [IdxW-1:0] idx_o
);

  // lowest set bit wins
  always_comb begin
    found_o = 1'b0;
    idx_o   = '0;
    for (int i = W - 1; i >= 0; i--) begin
      if (vec_i[i]) begin
        found_o = 1'b1;
        idx_o   = IdxW'(i);
      end
    end
  end

endmodule

// ----- design/msb_store.sv -----
module msb_store import msb_pkg::*; #(
  parameter int Width = $bits(slot_rec_t),
  parameter int Depth = SlotsDefault,
  parameter int AddrW = $clog2(SlotsDefault)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
